// ----- hdl/ptst_pkg.sv -----
`default_nettype none
package ptst_pkg;

  localparam int TIME_W = 10;
  localparam int SLOT_W = 4;
  localparam int OP_W   = 2;

  localparam logic [TIME_W-1:0] FRAME = TIME_W'(1000);

  localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
  localparam logic [OP_W-1:0] OP_FORCE  = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // one task slot as held by a cell
  typedef struct packed {
    logic              in_use;
    logic [TIME_W-1:0] due;
    logic [TIME_W-1:0] period;
  } slot_t;

  // one result beat
  typedef struct packed {
    logic              fired;
    logic [SLOT_W-1:0] slot;
    logic              full;
  } res_t;

  // fold a 10-bit value into the frame
  function automatic logic [TIME_W-1:0] fold_frame(input logic [TIME_W-1:0] v);
    fold_frame = (v >= FRAME) ? v - FRAME : v;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/ptst_cell.sv -----
`default_nettype none
module ptst_cell (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  shift,
  input  wire  ptst_pkg::slot_t d,
  output ptst_pkg::slot_t      q
);
  import ptst_pkg::*;

  slot_t slot_r;

  // take the neighbor's slot on every scan step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else if (shift) begin
      slot_r <= d;
    end
  end

  assign q = slot_r;

endmodule
`default_nettype wire

// ----- hdl/ptst_eval.sv -----
`default_nettype none
module ptst_eval (
  input  wire  [ptst_pkg::OP_W-1:0]   op,
  input  wire  [ptst_pkg::TIME_W-1:0] now,
  input  wire  [ptst_pkg::TIME_W-1:0] new_period,
  input  wire                         claim_ok,
  input  wire  ptst_pkg::slot_t       cur,
  output ptst_pkg::slot_t             upd,
  output logic                        hit
);
  import ptst_pkg::*;

  logic [TIME_W:0] sum;

  assign sum = {1'b0, cur.due} + {1'b0, cur.period};

  // decide on the slot at the head of the ring and compute its new value
  always_comb begin
    upd = cur;
    hit = 1'b0;
    unique case (op)
      OP_CREATE: begin
        if (!cur.in_use && claim_ok) begin
          hit        = 1'b1;
          upd.in_use = 1'b1;
          upd.due    = fold_frame(now);
          upd.period = fold_frame(new_period);
        end
      end
      OP_TICK: begin
        if (cur.in_use && (cur.due <= now)) begin
          hit = 1'b1;
          if (cur.period == '0) begin
            upd.in_use = 1'b0;
            upd.due    = '0;
          end else if (sum >= {1'b0, FRAME}) begin
            upd.due = TIME_W'(sum - {1'b0, FRAME});
          end else begin
            upd.due = sum[TIME_W-1:0];
          end
        end
      end
      OP_FORCE: begin
        hit = cur.in_use;
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/periodic_task_slot_timer.sv -----
// Periodic task slot timer: a ring of SLOTS cells rotated past one evaluator.
// A create, tick or force beat is accepted in idle, scans SLOTS slots (one slot
// per cycle unless a new hit meets a held result and a busy output) and flushes.
// A result is held until the next firing slot is scanned and shows in the cycle
// after; the last result shows after the flush. Opcode 3 is taken and ignored.
// Reset (synchronous, rst_n low) empties every slot.
`default_nettype none
module periodic_task_slot_timer #(
  parameter int SLOTS = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [23:0] in_tdata,   // [9:0] local_time, [19:10] period, zero pad
  input  wire  [1:0]  in_tuser,   // [1:0] opcode
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata,  // [3:0] slot, zero pad
  output logic [1:0]  out_tuser,  // [0] fired, [1] table_full
  output logic        out_tlast
);
  import ptst_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [IW-1:0]     cnt_r, cnt_nxt;
  logic [OP_W-1:0]   op_r;
  logic [TIME_W-1:0] time_r;
  logic [TIME_W-1:0] per_r;
  logic              pend_v_r, pend_v_nxt;
  res_t              pend_r, pend_nxt;
  logic              out_v_r, out_v_nxt;
  res_t              out_r, out_nxt;
  logic              out_last_r, out_last_nxt;

  slot_t             q [SLOTS];
  slot_t             d [SLOTS];
  slot_t             upd;
  logic              hit;
  logic              out_busy;
  logic              stall;
  logic              step;
  logic              scan_end;
  logic [SLOT_W-1:0] slot_idx;

  // ring of slot cells; the head slot goes back in at the tail, updated
  for (genvar i = 0; i < SLOTS; i++) begin : g_ring
    if (i == SLOTS - 1) begin : g_tail
      assign d[i] = upd;
    end else begin : g_mid
      assign d[i] = q[i+1];
    end
    ptst_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .shift (step),
      .d     (d[i]),
      .q     (q[i])
    );
  end

  ptst_eval u_eval (
    .op         (op_r),
    .now        (time_r),
    .new_period (per_r),
    .claim_ok   (!pend_v_r),
    .cur        (q[0]),
    .upd        (upd),
    .hit        (hit)
  );

  // slot index masked to the result field
  if (IW >= SLOT_W) begin : g_idx_wide
    assign slot_idx = cnt_r[SLOT_W-1:0];
  end else begin : g_idx_narrow
    assign slot_idx = {{(SLOT_W-IW){1'b0}}, cnt_r};
  end

  assign out_busy = out_v_r && !out_tready;
  assign stall    = hit && pend_v_r && out_busy;
  assign step     = (state_r == ST_SCAN) && !stall;
  assign scan_end = (cnt_r == IW'(SLOTS - 1));

  // sequencer, held result and output register
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    pend_v_nxt   = pend_v_r;
    pend_nxt     = pend_r;
    out_v_nxt    = out_v_r && !out_tready;
    out_nxt      = out_r;
    out_last_nxt = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid && (in_tuser != OP_UNUSED)) begin
          state_nxt  = ST_SCAN;
          cnt_nxt    = '0;
          pend_v_nxt = 1'b0;
        end
      end
      ST_SCAN: begin
        if (step) begin
          cnt_nxt = cnt_r + 1'b1;
          if (hit) begin
            // a new hit pushes the held one out, not last
            if (pend_v_r) begin
              out_v_nxt    = 1'b1;
              out_nxt      = pend_r;
              out_last_nxt = 1'b0;
            end
            pend_v_nxt    = 1'b1;
            pend_nxt.fired = (op_r != OP_CREATE);
            pend_nxt.slot  = slot_idx;
            pend_nxt.full  = 1'b0;
          end else if (scan_end && (op_r == OP_CREATE) && !pend_v_r) begin
            // no free slot found
            pend_v_nxt = 1'b1;
            pend_nxt   = '{fired: 1'b0, slot: '0, full: 1'b1};
          end
          if (scan_end) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = ST_IDLE;
        end else if (!out_busy) begin
          out_v_nxt    = 1'b1;
          out_nxt      = pend_r;
          out_last_nxt = 1'b1;
          pend_v_nxt   = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
    if (in_tvalid && in_tready) begin
      op_r   <= in_tuser;
      time_r <= in_tdata[TIME_W-1:0];
      per_r  <= in_tdata[2*TIME_W-1:TIME_W];
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'd0, out_r.slot};
  assign out_tuser  = {out_r.full, out_r.fired};
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire
